[rtl/crsm_pkg.sv]
`default_nettype none

package crsm_pkg;

  // Default ring size in bytes
  localparam int unsigned CAPACITY_DEF = 4096;

  // Fixed field widths of the request and response beats
  localparam int unsigned TYPE_W   = 4;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LENGTH_W = 13;
  localparam int unsigned STATUS_W = 2;

  // Request operation codes
  typedef enum logic [TYPE_W-1:0] {
    OP_RSV_WRITE     = 4'd0,
    OP_RSV_READ      = 4'd1,
    OP_RSV_ALL_WRITE = 4'd2,
    OP_RSV_ALL_READ  = 4'd3,
    OP_DROP_WRITER   = 4'd4,
    OP_DROP_READER   = 4'd5,
    OP_COMMIT_WRITE  = 4'd6,
    OP_COMMIT_READ   = 4'd7,
    OP_CLEAR         = 4'd8
  } op_t;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_MISUSE  = 2'd2
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_req;
    logic execute;
  } cmd_t;

  // One response beat
  typedef struct packed {
    status_t               status;
    logic [OFFSET_W-1:0]   region_offset;
    logic [LENGTH_W-1:0]   region_length;
    logic                  now_full;
    logic                  now_empty;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/crsm_req_if.sv]
`default_nettype none

interface crsm_req_if;
  import crsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   req_type;
  logic [SIZE_W-1:0]   req_size;

  modport source (output valid, output req_type, output req_size, input ready);
  modport sink   (input valid, input req_type, input req_size, output ready);
endinterface

`default_nettype wire

[rtl/crsm_rsp_if.sv]
`default_nettype none

interface crsm_rsp_if;
  import crsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] region_offset;
  logic [LENGTH_W-1:0] region_length;
  logic                now_full;
  logic                now_empty;

  modport source (output valid, output status, output region_offset, output region_length,
                  output now_full, output now_empty, input ready);
  modport sink   (input valid, input status, input region_offset, input region_length,
                  input now_full, input now_empty, output ready);
endinterface

`default_nettype wire

[rtl/crsm_ctrl.sv]
`default_nettype none

module crsm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output crsm_pkg::cmd_t     cmd
);
  import crsm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  // The response register can take a new beat when empty or draining now
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Sequence: take a request, then execute it once the response slot is free
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.load_req   = 1'b0;
    cmd.execute    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.execute    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[rtl/crsm_dp.sv]
`default_nettype none

module crsm_dp #(
  parameter int unsigned CAPACITY = crsm_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire crsm_pkg::cmd_t               cmd,
  input  wire logic [crsm_pkg::TYPE_W-1:0]  req_type,
  input  wire logic [crsm_pkg::SIZE_W-1:0]  req_size,
  output crsm_pkg::rsp_t                    rsp
);
  import crsm_pkg::*;

  // Cursor width, count width, and a working width that holds sums and sizes
  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned W  = (LW > SIZE_W) ? LW : SIZE_W;
  localparam int unsigned AW = W + 1;
  localparam logic [AW-1:0] CAP = AW'(CAPACITY);

  // Ring state
  logic [PW-1:0] read_pos, write_pos;
  logic [LW-1:0] tail_mark, write_granted, read_granted;
  logic          full_flag, writer_busy, reader_busy;

  // Latched request
  logic [TYPE_W-1:0] req_type_q;
  logic [SIZE_W-1:0] req_size_q;

  // Working copies in the wide domain
  logic [AW-1:0] rp, wp, tm, wg, rg, sz, run, s, sum, rp1, tm1;
  logic [AW-1:0] rp_n, wp_n, tm_n, wg_n, rg_n, off, len;
  logic          full_n, wbusy_n, rbusy_n;
  status_t       st;

  always_comb begin
    rp = AW'(read_pos);
    wp = AW'(write_pos);
    tm = AW'(tail_mark);
    wg = AW'(write_granted);
    rg = AW'(read_granted);
    sz = AW'(req_size_q);

    rp_n    = rp;
    wp_n    = wp;
    tm_n    = tm;
    wg_n    = wg;
    rg_n    = rg;
    full_n  = full_flag;
    wbusy_n = writer_busy;
    rbusy_n = reader_busy;
    st      = ST_OK;
    off     = '0;
    len     = '0;
    run     = '0;
    s       = '0;
    sum     = '0;
    rp1     = (rp == tm) ? '0 : rp;
    tm1     = (rp == tm) ? CAP : tm;

    unique case (req_type_q) inside
      OP_RSV_WRITE, OP_RSV_ALL_WRITE: begin
        run = (rp <= wp) ? (CAP - wp) : (rp - wp);
        if ((req_type_q == OP_RSV_WRITE && sz == '0) || writer_busy) begin
          st = ST_MISUSE;
        end else if (full_flag) begin
          st = ST_REFUSED;
        end else if (req_type_q == OP_RSV_ALL_WRITE) begin
          if (run == '0) begin
            st = ST_REFUSED;
          end else begin
            off = wp;
            len = run;
          end
        end else if (sz <= run) begin
          off = wp;
          len = sz;
        end else if (rp <= wp && sz <= rp) begin
          // Skip to the front and mark the old tail
          tm_n = wp;
          wp_n = '0;
          off  = '0;
          len  = sz;
        end else begin
          st = ST_REFUSED;
        end
        if (st == ST_OK) begin
          wbusy_n = 1'b1;
          wg_n    = len;
        end
      end
      OP_RSV_READ, OP_RSV_ALL_READ: begin
        if ((req_type_q == OP_RSV_READ && sz == '0) || reader_busy) begin
          st = ST_MISUSE;
        end else begin
          // Wrap the read cursor at the tail mark, even when refused
          rp_n = rp1;
          tm_n = tm1;
          if (rp1 < wp) begin
            run = wp - rp1;
          end else if (tm1 < rp1) begin
            run = '0;
          end else begin
            run = tm1 - rp1;
          end
          if (req_type_q == OP_RSV_READ && sz < run) begin
            run = sz;
          end
          if ((!full_flag && rp1 == wp) || run == '0) begin
            st = ST_REFUSED;
          end else begin
            off     = rp1;
            len     = run;
            rbusy_n = 1'b1;
            rg_n    = run;
          end
        end
      end
      OP_DROP_WRITER: begin
        if (!writer_busy) begin
          st = ST_MISUSE;
        end else begin
          wbusy_n = 1'b0;
          wg_n    = '0;
        end
      end
      OP_DROP_READER: begin
        if (!reader_busy) begin
          st = ST_MISUSE;
        end else begin
          rbusy_n = 1'b0;
          rg_n    = '0;
        end
      end
      OP_COMMIT_WRITE: begin
        s   = (sz == '0) ? wg : sz;
        sum = wp + s;
        if (!writer_busy || s > wg || sum > CAP) begin
          st = ST_MISUSE;
        end else begin
          wp_n    = (sum == CAP) ? '0 : sum;
          full_n  = (wp_n == rp);
          wbusy_n = 1'b0;
          wg_n    = '0;
        end
      end
      OP_COMMIT_READ: begin
        s   = (sz == '0) ? rg : sz;
        sum = rp + s;
        if (!reader_busy || s > rg || sum > tm) begin
          st = ST_MISUSE;
        end else begin
          rp_n = sum;
          if (sum == tm) begin
            rp_n = '0;
            tm_n = CAP;
          end
          full_n  = 1'b0;
          rbusy_n = 1'b0;
          rg_n    = '0;
          // Drained with no writer: restart both cursors at the front
          if (!writer_busy && rp_n == wp) begin
            rp_n = '0;
            wp_n = '0;
            tm_n = CAP;
          end
        end
      end
      OP_CLEAR: begin
        if (writer_busy || reader_busy) begin
          st = ST_MISUSE;
        end else begin
          rp_n   = '0;
          wp_n   = '0;
          tm_n   = CAP;
          full_n = 1'b0;
        end
      end
      default: st = ST_MISUSE;
    endcase
  end

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_q <= req_type;
      req_size_q <= req_size;
    end
  end

  // Update the ring state on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pos      <= '0;
      write_pos     <= '0;
      tail_mark     <= LW'(CAPACITY);
      full_flag     <= 1'b0;
      writer_busy   <= 1'b0;
      reader_busy   <= 1'b0;
      write_granted <= '0;
      read_granted  <= '0;
    end else if (cmd.execute) begin
      read_pos      <= PW'(rp_n);
      write_pos     <= PW'(wp_n);
      tail_mark     <= LW'(tm_n);
      full_flag     <= full_n;
      writer_busy   <= wbusy_n;
      reader_busy   <= rbusy_n;
      write_granted <= LW'(wg_n);
      read_granted  <= LW'(rg_n);
    end
  end

  // Hold the response beat until the next execute
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp.status        <= st;
      rsp.region_offset <= OFFSET_W'(off);
      rsp.region_length <= LENGTH_W'(len);
      rsp.now_full      <= full_n;
      rsp.now_empty     <= !full_n && (rp_n == wp_n);
    end
  end

endmodule

`default_nettype wire

[rtl/contiguous_ring_space_manager_top.sv]
`default_nettype none
// A request beat is latched when accepted, then executed into the response register;
// no new request is accepted until the previous one has executed.
// Execute waits while a previous response beat is still held.
// Reset (rst, synchronous, active high): both cursors at 0, tail mark at CAPACITY,
// no reservations, not full; no response pending.

module contiguous_ring_space_manager_top #(
  parameter int unsigned CAPACITY = crsm_pkg::CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  crsm_req_if.sink   req,
  crsm_rsp_if.source rsp
);
  import crsm_pkg::*;

  cmd_t cmd;
  rsp_t rsp_data;

  crsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  crsm_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_type (req.req_type),
    .req_size (req.req_size),
    .rsp      (rsp_data)
  );

  // Drive the response payload
  assign rsp.status        = rsp_data.status;
  assign rsp.region_offset = rsp_data.region_offset;
  assign rsp.region_length = rsp_data.region_length;
  assign rsp.now_full      = rsp_data.now_full;
  assign rsp.now_empty     = rsp_data.now_empty;

endmodule

`default_nettype wire

[sim/contiguous_ring_space_manager_top_test.sv]
`timescale 1ns / 1ps

module contiguous_ring_space_manager_top_test;
  import crsm_pkg::*;

  localparam int unsigned RING_BYTES = CAPACITY_DEF;
  localparam int unsigned RANDOM_REQUESTS = 750;
  // Opcode outside the defined set, answered as misuse
  localparam logic [TYPE_W-1:0] OP_UNDEFINED = 4'hF;

  // Tracks ring cursors and queues the response each accepted request must produce
  class cursor_scoreboard;
    bit [OFFSET_W-1:0] read_pos;
    bit [OFFSET_W-1:0] write_pos;
    bit [LENGTH_W-1:0] tail_mark;
    bit [LENGTH_W-1:0] write_granted;
    bit [LENGTH_W-1:0] read_granted;
    bit                full_flag;
    bit                writer_busy;
    bit                reader_busy;
    rsp_t              expected_rsps[$];
    int unsigned       errors;

    function new();
      read_pos      = '0;
      write_pos     = '0;
      tail_mark     = LENGTH_W'(RING_BYTES);
      write_granted = '0;
      read_granted  = '0;
      full_flag     = 1'b0;
      writer_busy   = 1'b0;
      reader_busy   = 1'b0;
      errors        = 0;
    endfunction

    function bit ring_empty();
      return !full_flag && read_pos == write_pos;
    endfunction

    // Jump the read cursor back to the front once it reaches the tail mark
    function void wrap_reader();
      if (LENGTH_W'(read_pos) == tail_mark) begin
        read_pos  = '0;
        tail_mark = LENGTH_W'(RING_BYTES);
      end
    endfunction

    function int unsigned readable_span();
      if (read_pos < write_pos) return 32'(write_pos) - 32'(read_pos);
      if (tail_mark < LENGTH_W'(read_pos)) return 0;
      return 32'(tail_mark) - 32'(read_pos);
    endfunction

    function void note_request(logic [TYPE_W-1:0] op, logic [SIZE_W-1:0] size);
      rsp_t        want;
      status_t     st;
      int unsigned sz;
      int unsigned span;
      int unsigned nxt;
      int unsigned off;
      int unsigned len;
      sz  = 32'(size);
      st  = ST_OK;
      off = 0;
      len = 0;
      case (op)
        OP_RSV_WRITE, OP_RSV_ALL_WRITE: begin
          if ((op == OP_RSV_WRITE && sz == 0) || writer_busy) begin
            st = ST_MISUSE;
          end else if (full_flag) begin
            st = ST_REFUSED;
          end else begin
            span = (read_pos <= write_pos) ? RING_BYTES - 32'(write_pos)
                                           : 32'(read_pos) - 32'(write_pos);
            if (op == OP_RSV_ALL_WRITE) begin
              if (span == 0) begin
                st = ST_REFUSED;
              end else begin
                off = 32'(write_pos);
                len = span;
              end
            end else if (sz <= span) begin
              off = 32'(write_pos);
              len = sz;
            end else if (read_pos <= write_pos && sz <= 32'(read_pos)) begin
              // skip to the front, old write cursor becomes the tail
              tail_mark = LENGTH_W'(write_pos);
              write_pos = '0;
              off       = 0;
              len       = sz;
            end else begin
              st = ST_REFUSED;
            end
            if (st == ST_OK) begin
              writer_busy   = 1'b1;
              write_granted = LENGTH_W'(len);
            end
          end
        end
        OP_RSV_READ, OP_RSV_ALL_READ: begin
          if ((op == OP_RSV_READ && sz == 0) || reader_busy) begin
            st = ST_MISUSE;
          end else begin
            wrap_reader();
            if (ring_empty()) begin
              st = ST_REFUSED;
            end else begin
              span = readable_span();
              if (op == OP_RSV_READ && sz < span) span = sz;
              if (span == 0) begin
                st = ST_REFUSED;
              end else begin
                off          = 32'(read_pos);
                len          = span;
                reader_busy  = 1'b1;
                read_granted = LENGTH_W'(len);
              end
            end
          end
        end
        OP_DROP_WRITER: begin
          if (!writer_busy) begin
            st = ST_MISUSE;
          end else begin
            writer_busy   = 1'b0;
            write_granted = '0;
          end
        end
        OP_DROP_READER: begin
          if (!reader_busy) begin
            st = ST_MISUSE;
          end else begin
            reader_busy  = 1'b0;
            read_granted = '0;
          end
        end
        OP_COMMIT_WRITE: begin
          if (!writer_busy) begin
            st = ST_MISUSE;
          end else begin
            if (sz == 0) sz = 32'(write_granted);
            if (sz > 32'(write_granted) || 32'(write_pos) + sz > RING_BYTES) begin
              st = ST_MISUSE;
            end else begin
              write_pos     = OFFSET_W'((32'(write_pos) + sz) % RING_BYTES);
              full_flag     = (write_pos == read_pos);
              writer_busy   = 1'b0;
              write_granted = '0;
            end
          end
        end
        OP_COMMIT_READ: begin
          if (!reader_busy) begin
            st = ST_MISUSE;
          end else begin
            if (sz == 0) sz = 32'(read_granted);
            nxt = 32'(read_pos) + sz;
            if (sz > 32'(read_granted) || nxt > 32'(tail_mark)) begin
              st = ST_MISUSE;
            end else begin
              if (nxt == 32'(tail_mark)) begin
                read_pos  = '0;
                tail_mark = LENGTH_W'(RING_BYTES);
              end else begin
                read_pos = OFFSET_W'(nxt);
              end
              full_flag    = 1'b0;
              reader_busy  = 1'b0;
              read_granted = '0;
              // drained: rewind everything to the front
              if (!writer_busy && read_pos == write_pos) begin
                read_pos  = '0;
                write_pos = '0;
                tail_mark = LENGTH_W'(RING_BYTES);
              end
            end
          end
        end
        OP_CLEAR: begin
          if (writer_busy || reader_busy) begin
            st = ST_MISUSE;
          end else begin
            read_pos  = '0;
            write_pos = '0;
            tail_mark = LENGTH_W'(RING_BYTES);
            full_flag = 1'b0;
          end
        end
        default: st = ST_MISUSE;
      endcase
      want.status        = st;
      want.region_offset = off[OFFSET_W-1:0];
      want.region_length = len[LENGTH_W-1:0];
      want.now_full      = full_flag;
      want.now_empty     = ring_empty();
      expected_rsps.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsps.size() == 0) begin
        $display("%0t: response beat with none expected, actual status %0d offset %0d len %0d",
                 $time, got.status, got.region_offset, got.region_length);
        errors++;
        return;
      end
      want = expected_rsps.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("region_offset", 32'(want.region_offset), 32'(got.region_offset));
      compare_field("region_length", 32'(want.region_length), 32'(got.region_length));
      compare_field("now_full", 32'(want.now_full), 32'(got.now_full));
      compare_field("now_empty", 32'(want.now_empty), 32'(got.now_empty));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned idle_mode = 0;
  int unsigned stall_left = 0;
  cursor_scoreboard sb = new();

  crsm_req_if req_if ();
  crsm_rsp_if rsp_if ();

  contiguous_ring_space_manager_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #6 clk = ~clk;

  // Idle length: mostly none or short, a few long; mode 1 never idles, mode 2 idles often
  function automatic int unsigned pick_gap(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 1) return 0;
    if (r < ((mode == 2) ? 30 : 60)) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return SIZE_W'($urandom_range(1, 64));
    if (r < 75) return SIZE_W'($urandom_range(1, 512));
    if (r < 95) return SIZE_W'($urandom_range(1, RING_BYTES));
    return SIZE_W'(RING_BYTES);
  endfunction

  // Commit size: whole reservation, a part of it, or one byte too many
  function automatic logic [SIZE_W-1:0] pick_commit(int unsigned granted);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 35) return SIZE_W'(granted + 1);
    return SIZE_W'($urandom_range(1, granted));
  endfunction

  // Drive one request beat; called and returns at a falling edge
  task automatic send_request(input logic [TYPE_W-1:0] op, input logic [SIZE_W-1:0] size);
    int unsigned gap;
    gap = pick_gap(idle_mode);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid    = 1'b1;
    req_if.req_type = op;
    req_if.req_size = size;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(op, size);
    @(negedge clk);
  endtask

  // Mostly well-formed reserve/commit traffic steered by the tracked cursor state
  task automatic send_random_request();
    int unsigned      r;
    logic [TYPE_W-1:0] op;
    logic [SIZE_W-1:0] size;
    r    = $urandom_range(0, 99);
    size = pick_size();
    if (r < 8) begin
      op   = TYPE_W'($urandom_range(0, 15));
      size = SIZE_W'($urandom_range(0, RING_BYTES));
    end else if (r < 10) begin
      op = OP_CLEAR;
    end else if (r < 56) begin
      if (!sb.writer_busy) begin
        op = ($urandom_range(0, 4) == 0) ? OP_RSV_ALL_WRITE : OP_RSV_WRITE;
      end else if ($urandom_range(0, 9) == 0) begin
        op = OP_DROP_WRITER;
      end else begin
        op   = OP_COMMIT_WRITE;
        size = pick_commit(32'(sb.write_granted));
      end
    end else begin
      if (!sb.reader_busy) begin
        op = ($urandom_range(0, 3) == 0) ? OP_RSV_ALL_READ : OP_RSV_READ;
      end else if ($urandom_range(0, 9) == 0) begin
        op = OP_DROP_READER;
      end else begin
        op   = OP_COMMIT_READ;
        size = pick_commit(32'(sb.read_granted));
      end
    end
    send_request(op, size);
  endtask

  // Response side: random backpressure
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(idle_mode);
      end
    end
  end

  // Check each response beat at the rising edge
  initial begin
    rsp_t got;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        got.status        = status_t'(rsp_if.status);
        got.region_offset = rsp_if.region_offset;
        got.region_length = rsp_if.region_length;
        got.now_full      = rsp_if.now_full;
        got.now_empty     = rsp_if.now_empty;
        sb.check_response(got);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = OP_CLEAR;
    req_if.req_size = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Misuse with nothing reserved or a zero size, refusals on an empty ring
    send_request(OP_COMMIT_WRITE, '0);
    send_request(OP_COMMIT_READ, '0);
    send_request(OP_DROP_WRITER, '0);
    send_request(OP_DROP_READER, '0);
    send_request(OP_RSV_READ, SIZE_W'(RING_BYTES));
    send_request(OP_RSV_ALL_READ, '0);
    send_request(OP_RSV_WRITE, '0);
    // Fill the whole ring, then read most of it back
    send_request(OP_RSV_WRITE, SIZE_W'(RING_BYTES));
    send_request(OP_RSV_ALL_WRITE, '0);
    send_request(OP_CLEAR, '0);
    send_request(OP_COMMIT_WRITE, '0);
    send_request(OP_RSV_ALL_WRITE, '0);
    send_request(OP_RSV_ALL_READ, '0);
    send_request(OP_COMMIT_READ, SIZE_W'(RING_BYTES - 1));
    send_request(OP_UNDEFINED, SIZE_W'(RING_BYTES));
    send_request(OP_CLEAR, '0);
    // Skip to front, read at the tail mark, clipped read, drain
    send_request(OP_RSV_WRITE, SIZE_W'(3000));
    send_request(OP_COMMIT_WRITE, '0);
    send_request(OP_RSV_WRITE, SIZE_W'(10));
    send_request(OP_COMMIT_WRITE, SIZE_W'(11));
    send_request(OP_RSV_ALL_READ, '0);
    send_request(OP_COMMIT_READ, '0);
    send_request(OP_DROP_WRITER, '0);
    send_request(OP_RSV_WRITE, SIZE_W'(2000));
    send_request(OP_COMMIT_WRITE, '0);
    send_request(OP_RSV_READ, SIZE_W'(1));
    send_request(OP_COMMIT_READ, '0);
    send_request(OP_RSV_READ, SIZE_W'(RING_BYTES));
    send_request(OP_COMMIT_READ, '0);

    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      idle_mode = (i / 120) % 3;
      send_random_request();
    end
    req_if.valid = 1'b0;
    idle_mode    = 0;

    // Drain outstanding responses, then watch for strays
    while (sb.expected_rsps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
